// ===== src/tsa_pkg.sv =====
// ----------------------------------------------------------------------------
// tsa_pkg: shared types and constants of the talk source arbiter
// Holds the status codes, register indexes, and the item and config structs.
// ----------------------------------------------------------------------------
package tsa_pkg;

    // Width of the stored timestamp; elapsed time wraps at this width.
    localparam int TIME_BITS = 32;
    // Width used to compare elapsed time against the 32-bit hold register.
    localparam int CMP_BITS  = (TIME_BITS > 32) ? TIME_BITS : 32;

    // Configuration port geometry.
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 32;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_BITS-1:0] CFG_CIPHER_DOMAIN = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PLAIN_DOMAIN  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MIX_MODE      = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SECURE_MODE   = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PTT_MODE      = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SWITCH_MARGIN = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HOLD_TICKS    = 3'd6;

    // Secure mode codes; the unused codes behave as crypto without handshake.
    localparam logic [1:0] SEC_NONE      = 2'd0;
    localparam logic [1:0] SEC_HANDSHAKE = 2'd2;

    // Reset values of the registers.
    localparam logic [7:0]  RST_CIPHER_DOMAIN = 8'd0;
    localparam logic [7:0]  RST_PLAIN_DOMAIN  = 8'd1;
    localparam logic [7:0]  RST_SWITCH_MARGIN = 8'd30;
    localparam logic [31:0] RST_HOLD_TICKS    = 32'd100000;
    localparam logic signed [7:0] RST_POWER_AVG = -8'sd127;

    // Status reported with each result word.
    typedef enum logic [1:0] {
        ST_TIMEOUT = 2'd0,
        ST_ACCEPT  = 2'd1,
        ST_BLOCKED = 2'd2,
        ST_IGNORED = 2'd3
    } t_status;

    typedef struct packed {
        logic [7:0]  cipher_domain;
        logic [7:0]  plain_domain;
        logic        mix_mode;
        logic [1:0]  secure_mode;
        logic        ptt_mode;
        logic [7:0]  switch_margin;
        logic [31:0] hold_ticks;
    } t_cfg;

    typedef struct packed {
        logic              frame_present;
        logic [7:0]        stream_index;
        logic [7:0]        domain_code;
        logic signed [7:0] frame_power;
        logic [31:0]       now_ticks;
        logic              cipher_active;
    } t_in_item;

    typedef struct packed {
        t_status    status;
        logic       ptt_level;
        logic       cipher_request;
        logic [7:0] active_stream;
    } t_out_item;

endpackage

// ===== src/talk_source_arbiter.sv =====
// The talk source arbiter takes one frame word per cycle while the output
// side keeps up and returns one result word for each, in order. A word
// passes an input register, is decided against the arbitration state
// combinationally, and lands in a result register. The rate is set by
// the update of the average, active stream, timestamp, request and talk
// registers that each frame must see from the frame before it. The user
// must see that configuration is written through the plain write port
// only while no word is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
// talk_source_arbiter: top level of the talk channel arbiter
// Stream input and output registers around the decision core and the
// configuration registers.
// ----------------------------------------------------------------------------
module talk_source_arbiter (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Frame input stream.
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // tdata fields from bit 0: stream_index[7:0], domain_code[15:8],
    // frame_power[23:16], now_ticks[55:24], cipher_active[56], zero fill.
    input  logic [63:0]                        i_s_axis_tdata,
    // tuser fields from bit 0: frame_present[0].
    input  logic                               i_s_axis_tuser,
    // Result output stream.
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // tdata fields from bit 0: ptt_level[0], cipher_request[1],
    // active_stream[9:2], zero fill.
    output logic [15:0]                        o_m_axis_tdata,
    // tuser fields from bit 0: status[1:0].
    output logic [1:0]                         o_m_axis_tuser,
    // Configuration write port.
    input  logic                               i_cfg_we,
    input  logic [tsa_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  logic [tsa_pkg::CFG_DATA_BITS-1:0]  i_cfg_wdata
);
    import tsa_pkg::*;

    t_cfg       w_cfg;
    t_in_item   r_in;
    logic       r_in_valid;
    t_out_item  w_result;
    t_out_item  r_out;
    logic       r_out_valid;
    logic       w_out_free;
    logic       w_step;
    logic       w_in_take;

    tsa_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg)
    );

    // Handshake: the result register frees when empty or being drained.
    assign w_out_free      = !r_out_valid || i_m_axis_tready;
    assign w_step          = r_in_valid && w_out_free;
    assign o_s_axis_tready = !r_in_valid || w_out_free;
    assign w_in_take       = i_s_axis_tvalid && o_s_axis_tready;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in.frame_present <= i_s_axis_tuser;
            r_in.stream_index  <= i_s_axis_tdata[7:0];
            r_in.domain_code   <= i_s_axis_tdata[15:8];
            r_in.frame_power   <= i_s_axis_tdata[23:16];
            r_in.now_ticks     <= i_s_axis_tdata[55:24];
            r_in.cipher_active <= i_s_axis_tdata[56];
        end
    end

    tsa_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (w_cfg),
        .i_step   (w_step),
        .i_item   (r_in),
        .o_result (w_result)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out <= w_result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out.status;
    assign o_m_axis_tdata  = {6'b0, r_out.active_stream, r_out.cipher_request,
                              r_out.ptt_level};

`ifndef SYNTH
    // Nothing is shown on the output in the cycle after reset.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid right after reset");

    // An accepted frame raises push-to-talk when the block drives it.
    a_accept_talk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tuser == ST_ACCEPT) && w_cfg.ptt_mode)
        |-> o_m_axis_tdata[0])
        else $error("accepted frame without push-to-talk");

    // A timeout or a blocked frame drops push-to-talk when the block drives it.
    a_drop_talk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && w_cfg.ptt_mode &&
         ((o_m_axis_tuser == ST_TIMEOUT) || (o_m_axis_tuser == ST_BLOCKED)))
        |-> !o_m_axis_tdata[0])
        else $error("push-to-talk held after timeout or block");

    // A word in the input register with a free result register moves on.
    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && w_out_free) |=> r_out_valid)
        else $error("decided word lost before the result register");
`endif

endmodule

// ===== src/tsa_cfg.sv =====
// ----------------------------------------------------------------------------
// tsa_cfg: configuration registers
// Holds the seven control registers written through the plain write port.
// ----------------------------------------------------------------------------
module tsa_cfg (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [tsa_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  logic [tsa_pkg::CFG_DATA_BITS-1:0]  i_cfg_wdata,
    output tsa_pkg::t_cfg                      o_cfg
);
    import tsa_pkg::*;

    t_cfg r_cfg;

    // Register file; writes beyond the list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cipher_domain <= RST_CIPHER_DOMAIN;
            r_cfg.plain_domain  <= RST_PLAIN_DOMAIN;
            r_cfg.mix_mode      <= 1'b0;
            r_cfg.secure_mode   <= SEC_NONE;
            r_cfg.ptt_mode      <= 1'b1;
            r_cfg.switch_margin <= RST_SWITCH_MARGIN;
            r_cfg.hold_ticks    <= RST_HOLD_TICKS;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_CIPHER_DOMAIN: r_cfg.cipher_domain <= i_cfg_wdata[7:0];
                CFG_PLAIN_DOMAIN:  r_cfg.plain_domain  <= i_cfg_wdata[7:0];
                CFG_MIX_MODE:      r_cfg.mix_mode      <= i_cfg_wdata[0];
                CFG_SECURE_MODE:   r_cfg.secure_mode   <= i_cfg_wdata[1:0];
                CFG_PTT_MODE:      r_cfg.ptt_mode      <= i_cfg_wdata[0];
                CFG_SWITCH_MARGIN: r_cfg.switch_margin <= i_cfg_wdata[7:0];
                CFG_HOLD_TICKS:    r_cfg.hold_ticks    <= i_cfg_wdata[31:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== src/tsa_core.sv =====
// ----------------------------------------------------------------------------
// tsa_core: arbitration state and per-frame decision
// Decides the status of one registered frame and updates the state in the
// same cycle, so the next frame sees the new state.
// ----------------------------------------------------------------------------
module tsa_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tsa_pkg::t_cfg       i_cfg,
    input  logic                i_step,
    input  tsa_pkg::t_in_item   i_item,
    output tsa_pkg::t_out_item  o_result
);
    import tsa_pkg::*;

    logic signed [7:0]      r_avg;
    logic [7:0]             r_active;
    logic [TIME_BITS-1:0]   r_last;
    logic                   r_req;
    logic                   r_talk;

    logic signed [7:0]      n_avg;
    logic [7:0]             n_active;
    logic [TIME_BITS-1:0]   n_last;
    logic                   n_req;
    logic                   n_talk;

    logic                   w_is_cipher;
    logic                   w_is_plain;
    logic                   w_on_active;
    logic signed [17:0]     w_avg18;
    logic signed [17:0]     w_acc;
    logic signed [17:0]     w_biased;
    logic signed [7:0]      w_avg_leak;
    logic signed [9:0]      w_diff;
    logic [TIME_BITS-1:0]   w_now_t;
    logic [TIME_BITS-1:0]   w_elapsed;
    logic                   w_takeover;
    logic                   w_blocked;
    t_status                w_status;

    assign w_is_cipher = (i_item.domain_code == i_cfg.cipher_domain);
    assign w_is_plain  = (i_item.domain_code == i_cfg.plain_domain);
    assign w_on_active = (i_item.stream_index == r_active) || i_cfg.mix_mode;

    // Leaky average: (old*1023 + p) / 1024, rounded toward zero.
    assign w_avg18    = 18'(r_avg);
    assign w_acc      = (w_avg18 <<< 10) - w_avg18 + 18'(i_item.frame_power);
    assign w_biased   = w_acc + (w_acc[17] ? 18'sd1023 : 18'sd0);
    assign w_avg_leak = 8'(w_biased >>> 10);

    // Takeover test: loud enough over the average, or silence past the hold.
    assign w_diff     = 10'(i_item.frame_power) - 10'(r_avg);
    assign w_now_t    = TIME_BITS'(i_item.now_ticks);
    assign w_elapsed  = w_now_t - r_last;
    assign w_takeover = (w_diff > $signed({2'b00, i_cfg.switch_margin})) ||
                        (CMP_BITS'(w_elapsed) > CMP_BITS'(i_cfg.hold_ticks));

    // Request level, then the secure checks against the updated request.
    always_comb begin
        n_req = r_req;
        if (i_item.frame_present) begin
            if (w_on_active) begin
                if (i_cfg.secure_mode != SEC_NONE) begin
                    n_req = w_is_cipher;
                end
            end else if (w_takeover) begin
                n_req = w_is_cipher;
            end
        end
        w_blocked = (i_cfg.secure_mode != SEC_NONE) &&
                    (!(w_is_cipher || w_is_plain) ||
                     ((i_cfg.secure_mode == SEC_HANDSHAKE) &&
                      (n_req != i_item.cipher_active)));
    end

    // Status, average, active stream.
    always_comb begin
        n_avg    = r_avg;
        n_active = r_active;
        if (!i_item.frame_present) begin
            w_status = ST_TIMEOUT;
        end else if (w_on_active) begin
            if (w_blocked) begin
                w_status = ST_BLOCKED;
            end else begin
                w_status = ST_ACCEPT;
                n_avg    = w_avg_leak;
            end
        end else if (w_takeover) begin
            n_avg    = i_item.frame_power;
            n_active = i_item.stream_index;
            w_status = w_blocked ? ST_BLOCKED : ST_ACCEPT;
        end else begin
            w_status = ST_IGNORED;
        end
    end

    // Push-to-talk and timestamp follow the status.
    always_comb begin
        n_talk = r_talk;
        n_last = r_last;
        if (w_status == ST_ACCEPT) begin
            n_last = w_now_t;
            if (i_cfg.ptt_mode) begin
                n_talk = 1'b1;
            end
        end else if ((w_status == ST_TIMEOUT) || (w_status == ST_BLOCKED)) begin
            if (i_cfg.ptt_mode) begin
                n_talk = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_avg    <= RST_POWER_AVG;
            r_active <= '0;
            r_last   <= '0;
            r_req    <= 1'b0;
            r_talk   <= 1'b0;
        end else if (i_step) begin
            r_avg    <= n_avg;
            r_active <= n_active;
            r_last   <= n_last;
            r_req    <= n_req;
            r_talk   <= n_talk;
        end
    end

    // Result word reflects the state after this frame.
    assign o_result.status         = w_status;
    assign o_result.ptt_level      = n_talk;
    assign o_result.cipher_request = n_req;
    assign o_result.active_stream  = n_active;

endmodule

// ===== bench/tb_talk_source_arbiter.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_talk_source_arbiter: self-checking bench for the talk source arbiter
// Frame words go in on the input stream and each result word is compared,
// field by field, against a cycle-free prediction of the arbitration state.
// A directed opener covers field extremes, takeover by margin and by hold
// time, time wrap, timeouts, blocking and mix mode; random phases then sweep
// several register settings under varying backpressure on both streams.
// ----------------------------------------------------------------------------
module tb_talk_source_arbiter;
    import tsa_pkg::*;

    localparam int LIMIT_CYCLES = 500000;
    localparam int PHASE_WORDS  = 160;
    localparam int STALL_CYCLES = 60;

    // Predicts every result word of the arbiter and checks the words that come back.
    class talk_scoreboard;
        t_cfg              cfg;
        logic signed [7:0] power_avg;
        logic [7:0]        active_idx;
        logic [31:0]       last_stamp;
        logic              req_lvl;
        logic              talk_lvl;
        t_out_item         pending_outcomes[$];
        int                mismatches;
        int                frames_noted;
        int                status_seen[4];

        function new();
            cfg.cipher_domain = RST_CIPHER_DOMAIN;
            cfg.plain_domain  = RST_PLAIN_DOMAIN;
            cfg.mix_mode      = 1'b0;
            cfg.secure_mode   = SEC_NONE;
            cfg.ptt_mode      = 1'b1;
            cfg.switch_margin = RST_SWITCH_MARGIN;
            cfg.hold_ticks    = RST_HOLD_TICKS;
            power_avg  = RST_POWER_AVG;
            active_idx = '0;
            last_stamp = '0;
            req_lvl    = 1'b0;
            talk_lvl   = 1'b0;
        endfunction

        function int pending();
            return pending_outcomes.size();
        endfunction

        // A blocked frame fails the domain check or, with handshake, the readback check.
        function bit is_blocked(logic is_ciph, logic is_plain, logic readback);
            if (cfg.secure_mode == SEC_NONE)
                return 1'b0;
            if (!(is_ciph || is_plain))
                return 1'b1;
            return (cfg.secure_mode == SEC_HANDSHAKE) && (req_lvl != readback);
        endfunction

        function void drop_talk();
            if (cfg.ptt_mode)
                talk_lvl = 1'b0;
        endfunction

        // Runs one accepted frame word through the arbitration rules.
        function void note_frame(t_in_item f);
            t_out_item         res;
            t_status           st;
            logic              is_ciph;
            logic              is_plain;
            logic signed [7:0] pw;
            logic [31:0]       elapsed;
            int                acc;
            is_ciph  = (f.domain_code == cfg.cipher_domain);
            is_plain = (f.domain_code == cfg.plain_domain);
            pw       = f.frame_power;
            if (!f.frame_present) begin
                drop_talk();
                st = ST_TIMEOUT;
            end else if (f.stream_index == active_idx || cfg.mix_mode) begin
                if (cfg.secure_mode != SEC_NONE)
                    req_lvl = is_ciph;
                if (is_blocked(is_ciph, is_plain, f.cipher_active)) begin
                    drop_talk();
                    st = ST_BLOCKED;
                end else begin
                    // Leaky average, division truncates toward zero.
                    acc = int'(power_avg) * 1023 + int'(pw);
                    power_avg = 8'(acc / 1024);
                    st = ST_ACCEPT;
                end
            end else begin
                elapsed = f.now_ticks - last_stamp;
                if (int'(pw) - int'(power_avg) > int'(cfg.switch_margin)
                        || elapsed > cfg.hold_ticks) begin
                    // Takeover keeps the new stream and average even when blocked.
                    power_avg  = pw;
                    active_idx = f.stream_index;
                    req_lvl    = is_ciph;
                    if (is_blocked(is_ciph, is_plain, f.cipher_active)) begin
                        drop_talk();
                        st = ST_BLOCKED;
                    end else begin
                        st = ST_ACCEPT;
                    end
                end else begin
                    st = ST_IGNORED;
                end
            end
            if (st == ST_ACCEPT) begin
                if (cfg.ptt_mode)
                    talk_lvl = 1'b1;
                last_stamp = f.now_ticks;
            end
            res.status         = st;
            res.ptt_level      = talk_lvl;
            res.cipher_request = req_lvl;
            res.active_stream  = active_idx;
            pending_outcomes.push_back(res);
            frames_noted++;
            status_seen[st]++;
        endfunction

        function void compare_field(string name, int want, int got);
            if (want != got) begin
                mismatches++;
                $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            end
        endfunction

        // Compares a result word with the oldest prediction.
        function void check_result(t_out_item got);
            t_out_item want;
            if (pending_outcomes.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result word: expected none, actual status %0d",
                         $time, got.status);
                return;
            end
            want = pending_outcomes.pop_front();
            compare_field("status", want.status, got.status);
            compare_field("ptt_level", want.ptt_level, got.ptt_level);
            compare_field("cipher_request", want.cipher_request, got.cipher_request);
            compare_field("active_stream", want.active_stream, got.active_stream);
        endfunction
    endclass

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_s_axis_tvalid;
    logic                     o_s_axis_tready;
    logic [63:0]              i_s_axis_tdata;
    logic                     i_s_axis_tuser;
    logic                     o_m_axis_tvalid;
    logic                     i_m_axis_tready;
    logic [15:0]              o_m_axis_tdata;
    logic [1:0]               o_m_axis_tuser;
    logic                     i_cfg_we;
    logic [CFG_IDX_BITS-1:0]  i_cfg_index;
    logic [CFG_DATA_BITS-1:0] i_cfg_wdata;

    talk_scoreboard sb;
    t_cfg           cur_cfg;
    t_cfg           phase_cfg[8];
    logic [31:0]    tick_now;
    int             send_idle_pct;
    int             recv_idle_pct;
    bit             stall_request;
    int             stall_left;
    int             cycle_count;
    int             input_stall_cycles;

    talk_source_arbiter u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    // Clock.
    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("Run timed out after %0d cycles with %0d words outstanding.",
                     cycle_count, sb.pending());
            $display("tb_talk_source_arbiter: FAIL");
            $finish;
        end
    end

    // Result side readiness: a long hold-off on request, otherwise random idling.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else if (stall_request) begin
            stall_request = 1'b0;
            stall_left = STALL_CYCLES - 1;
            i_m_axis_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Result monitor.
    always @(posedge i_clk) begin
        t_out_item got;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.status         = t_status'(o_m_axis_tuser);
            got.ptt_level      = o_m_axis_tdata[0];
            got.cipher_request = o_m_axis_tdata[1];
            got.active_stream  = o_m_axis_tdata[9:2];
            sb.check_result(got);
        end
    end

    function automatic t_in_item mk(logic present, logic [7:0] stream, logic [7:0] domain,
                                    logic [7:0] power, logic [31:0] now, logic ca);
        t_in_item f;
        f.frame_present = present;
        f.stream_index  = stream;
        f.domain_code   = domain;
        f.frame_power   = power;
        f.now_ticks     = now;
        f.cipher_active = ca;
        return f;
    endfunction

    function automatic t_cfg make_cfg(logic [7:0] cd, logic [7:0] pd, logic mix,
                                      logic [1:0] sec, logic ptt, logic [7:0] margin,
                                      logic [31:0] hold);
        t_cfg c;
        c.cipher_domain = cd;
        c.plain_domain  = pd;
        c.mix_mode      = mix;
        c.secure_mode   = sec;
        c.ptt_mode      = ptt;
        c.switch_margin = margin;
        c.hold_ticks    = hold;
        return c;
    endfunction

    // Mostly frames of the current talker in known domains with a running
    // clock, mixed with rival streams, foreign domains and time jumps.
    function automatic t_in_item random_frame();
        t_in_item f;
        int       r;
        f = mk(1'b1, '0, '0, '0, '0, 1'b0);
        r = $urandom_range(99);
        if (r < 80)
            tick_now += $urandom_range(1, 40);
        else if (r < 92)
            tick_now += cur_cfg.hold_ticks + $urandom_range(1, 64);
        else
            tick_now = $urandom;
        if ($urandom_range(99) < 6) begin
            f = mk(1'b0, 8'($urandom), 8'($urandom), 8'($urandom), $urandom, 1'($urandom));
            return f;
        end
        r = $urandom_range(99);
        if (r < 65)
            f.stream_index = sb.active_idx;
        else if (r < 85)
            f.stream_index = 8'($urandom_range(3));
        else
            f.stream_index = 8'($urandom);
        r = $urandom_range(99);
        if (r < 40)
            f.domain_code = cur_cfg.cipher_domain;
        else if (r < 80)
            f.domain_code = cur_cfg.plain_domain;
        else
            f.domain_code = 8'($urandom);
        if ($urandom_range(99) < 20)
            f.frame_power = 8'($urandom_range(64, 127));
        else
            f.frame_power = 8'($urandom);
        f.now_ticks = tick_now;
        if ($urandom_range(99) < 85)
            f.cipher_active = (f.domain_code == cur_cfg.cipher_domain);
        else
            f.cipher_active = 1'($urandom);
        return f;
    endfunction

    // Offers one frame word, with random idle cycles ahead of it.
    task automatic send_frame(t_in_item f);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {7'b0, f.cipher_active, f.now_ticks, f.frame_power,
                            f.domain_code, f.stream_index};
        i_s_axis_tuser  <= f.frame_present;
        @(posedge i_clk);
        while (!o_s_axis_tready) begin
            input_stall_cycles++;
            @(posedge i_clk);
        end
        sb.note_frame(f);
    endtask

    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
    endtask

    // Waits for the last result word, lets the pipeline settle, then writes all registers.
    task automatic apply_settings(t_cfg c);
        i_s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        write_reg(CFG_CIPHER_DOMAIN, CFG_DATA_BITS'(c.cipher_domain));
        write_reg(CFG_PLAIN_DOMAIN, CFG_DATA_BITS'(c.plain_domain));
        write_reg(CFG_MIX_MODE, CFG_DATA_BITS'(c.mix_mode));
        write_reg(CFG_SECURE_MODE, CFG_DATA_BITS'(c.secure_mode));
        write_reg(CFG_PTT_MODE, CFG_DATA_BITS'(c.ptt_mode));
        write_reg(CFG_SWITCH_MARGIN, CFG_DATA_BITS'(c.switch_margin));
        write_reg(CFG_HOLD_TICKS, CFG_DATA_BITS'(c.hold_ticks));
        i_cfg_we <= 1'b0;
        cur_cfg = c;
        sb.cfg  = c;
    endtask

    // Main sequence.
    initial begin
        sb = new();
        cur_cfg = sb.cfg;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        stall_request = 1'b0;
        stall_left = 0;
        cycle_count = 0;
        input_stall_cycles = 0;
        tick_now = '0;
        i_rst_n         <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        i_s_axis_tuser  <= 1'b0;
        i_m_axis_tready <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_index     <= '0;
        i_cfg_wdata     <= '0;
        phase_cfg[0] = make_cfg(8'h00, 8'h01, 1'b0, 2'd0, 1'b1, 8'd30, 32'd100000);
        phase_cfg[1] = make_cfg(8'hFF, 8'h00, 1'b0, 2'd1, 1'b1, 8'd0, 32'd0);
        phase_cfg[2] = make_cfg(8'hA5, 8'h5A, 1'b1, 2'd2, 1'b0, 8'd255, 32'hFFFF_FFFF);
        phase_cfg[3] = make_cfg(8'h07, 8'h07, 1'b0, 2'd3, 1'b1, 8'd10, 32'd500);
        phase_cfg[4] = make_cfg(8'h03, 8'h04, 1'b0, 2'd2, 1'b1, 8'd20, 32'd2000);
        phase_cfg[5] = make_cfg(8'h80, 8'h7F, 1'b1, 2'd0, 1'b1, 8'd127, 32'd1);
        phase_cfg[6] = make_cfg(8'h11, 8'h22, 1'b0, 2'd2, 1'b0, 8'd5, 32'd300);
        phase_cfg[7] = make_cfg(8'h01, 8'hFE, 1'b0, 2'd1, 1'b1, 8'd200, 32'h8000_0000);
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed opener under the reset settings: timeouts, field extremes,
        // takeover by margin and by hold time, and elapsed time across the wrap.
        send_frame(mk(1'b0, 8'hFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 1'b1));
        send_frame(mk(1'b1, 8'h00, 8'h00, 8'h7F, 32'd0, 1'b0));
        send_frame(mk(1'b1, 8'h00, 8'h01, 8'h80, 32'd5, 1'b1));
        send_frame(mk(1'b1, 8'h80, 8'h55, 8'h80, 32'd10, 1'b0));
        send_frame(mk(1'b1, 8'h80, 8'hAA, 8'h7F, 32'd20, 1'b0));
        send_frame(mk(1'b1, 8'h01, 8'h00, 8'h00, 32'd100020, 1'b0));
        send_frame(mk(1'b1, 8'h01, 8'h00, 8'h00, 32'd100021, 1'b0));
        send_frame(mk(1'b1, 8'h01, 8'h01, 8'h40, 32'hFFFF_FFF0, 1'b1));
        send_frame(mk(1'b1, 8'h02, 8'h00, 8'h9C, 32'h0000_0010, 1'b0));
        send_frame(mk(1'b0, 8'h00, 8'h00, 8'h00, 32'd0, 1'b0));
        send_frame(mk(1'b1, 8'hFE, 8'hFF, 8'h7F, 32'h0000_0020, 1'b1));

        // Handshake mode: foreign domain, readback disagreement, clean frames,
        // and a takeover that is then blocked.
        apply_settings(make_cfg(8'h10, 8'h20, 1'b0, 2'd2, 1'b1, 8'd0, 32'd1000));
        send_frame(mk(1'b1, 8'hFE, 8'h33, 8'h0A, 32'h100, 1'b0));
        send_frame(mk(1'b1, 8'hFE, 8'h10, 8'h0A, 32'h101, 1'b0));
        send_frame(mk(1'b1, 8'hFE, 8'h10, 8'h0A, 32'h102, 1'b1));
        send_frame(mk(1'b1, 8'hFE, 8'h20, 8'h0A, 32'h103, 1'b0));
        send_frame(mk(1'b1, 8'h07, 8'h10, 8'h7F, 32'h104, 1'b0));
        send_frame(mk(1'b0, 8'h07, 8'h10, 8'h00, 32'h105, 1'b0));

        // Mix mode with the spare secure code and push-to-talk not driven.
        apply_settings(make_cfg(8'h10, 8'h20, 1'b1, 2'd3, 1'b0, 8'd30, 32'd1000));
        send_frame(mk(1'b1, 8'h44, 8'h99, 8'h00, 32'h200, 1'b1));
        send_frame(mk(1'b1, 8'h55, 8'h10, 8'hFB, 32'h201, 1'b0));
        send_frame(mk(1'b0, 8'h55, 8'h10, 8'hFB, 32'h202, 1'b0));

        // Random phases: sender-light then receiver-light idling, then none.
        for (int p = 0; p < 8; p++) begin
            apply_settings(phase_cfg[p]);
            if (p < 3) begin
                send_idle_pct = 7;
                recv_idle_pct = 87;
            end else if (p < 6) begin
                send_idle_pct = 87;
                recv_idle_pct = 7;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (p == 6)
                stall_request = 1'b1;
            tick_now = $urandom;
            for (int k = 0; k < PHASE_WORDS; k++)
                send_frame(random_frame());
        end

        // Drain and settle.
        i_s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Checked %0d frame words over 10 register settings in %0d cycles.",
                 sb.frames_noted, cycle_count);
        $display("Outcomes: %0d accepted, %0d blocked, %0d ignored, %0d timeouts; %0d input stalls.",
                 sb.status_seen[ST_ACCEPT], sb.status_seen[ST_BLOCKED],
                 sb.status_seen[ST_IGNORED], sb.status_seen[ST_TIMEOUT], input_stall_cycles);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("tb_talk_source_arbiter: PASS");
        else
            $display("tb_talk_source_arbiter: FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/tsa_pkg.sv
src/tsa_cfg.sv
src/tsa_core.sv
src/talk_source_arbiter.sv
bench/tb_talk_source_arbiter.sv
